// ===== rtl/assert_macros.svh =====
// Shared assertion helpers; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define LSSF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds out of reset.
`define LSSF_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/lssf_pkg.sv =====
`default_nettype none
package lssf_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned LogPoints = $clog2(MaxPoints);
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned SumW      = CoordW + LogPoints;
  localparam int unsigned SqW       = 2 * CoordW + LogPoints;
  localparam int unsigned ProdW     = CountW + SqW;
  localparam int unsigned FracW     = 16;
  localparam int unsigned QuotW     = ProdW + FracW;
  localparam int unsigned DivCntW   = $clog2(QuotW);
  localparam int unsigned SlopeW    = 32;
  localparam int unsigned ThrW      = 31;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned MulAW     = SumW;
  localparam int unsigned MulBW     = SqW;
  localparam int unsigned MulW      = MulAW + MulBW;

  localparam logic [ThrW-1:0]   ThrReset  = ThrW'(6554);
  localparam logic [SlopeW-1:0] MagLimPos = 32'h7FFF_FFFF;
  localparam logic [SlopeW-1:0] MagLimNeg = 32'h8000_0000;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              last_point;
  } point_t;

  typedef struct packed {
    logic signed [SlopeW-1:0] slope;
    logic                     degenerate;
    logic                     tilted;
    logic                     points_dropped;
    logic [CountW-1:0]        point_count;
  } fit_t;

  // Accumulated sums of one point set, handed from front to back.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
    logic [SqW-1:0]    sum_xx;
    logic [SqW-1:0]    sum_xy;
    logic              dropped;
  } acc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StMulC,
    StMulD,
    StSign,
    StDiv,
    StOut
  } back_st_e;

endpackage
`default_nettype wire

// ===== rtl/lssf_front.sv =====
`default_nettype none
module lssf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lssf_pkg::point_t in_data_i,
  input  wire logic            fifo_full_i,
  output logic                 push_o,
  output lssf_pkg::acc_t       push_data_o
);
  import lssf_pkg::*;
  `include "assert_macros.svh"

  acc_t cur_q, cur_d, nxt;
  logic [2*CoordW-1:0] xx, xy;
  logic full;
  logic xfer;

  assign in_ready_o = !fifo_full_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign full       = (cur_q.count == CountW'(MaxPoints));

  assign xx = {{CoordW{1'b0}}, in_data_i.point_x} * {{CoordW{1'b0}}, in_data_i.point_x};
  assign xy = {{CoordW{1'b0}}, in_data_i.point_x} * {{CoordW{1'b0}}, in_data_i.point_y};

  always_comb begin
    nxt = cur_q;
    if (!full) begin
      nxt.count  = cur_q.count + CountW'(1);
      nxt.sum_x  = cur_q.sum_x + SumW'(in_data_i.point_x);
      nxt.sum_y  = cur_q.sum_y + SumW'(in_data_i.point_y);
      nxt.sum_xx = cur_q.sum_xx + SqW'(xx);
      nxt.sum_xy = cur_q.sum_xy + SqW'(xy);
    end else begin
      // drop the point once capacity is reached
      nxt.dropped = 1'b1;
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (xfer) begin
      cur_d = in_data_i.last_point ? '0 : nxt;
    end
  end

  assign push_o      = xfer && in_data_i.last_point;
  assign push_data_o = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  `LSSF_ASSERT(clear_after_last, push_o |=> (cur_q.count == '0 && !cur_q.dropped), "sums not cleared after last point")
  `LSSF_NEVER(count_in_range, cur_q.count > CountW'(MaxPoints), "point count beyond capacity")

endmodule
`default_nettype wire

// ===== rtl/lssf_fifo.sv =====
`default_nettype none
module lssf_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lssf_pkg::acc_t   push_data_i,
  input  wire logic             pop_i,
  output lssf_pkg::acc_t        pop_data_o,
  output lssf_pkg::fifo_stat_t  stat_o
);
  import lssf_pkg::*;
  `include "assert_macros.svh"

  acc_t mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `LSSF_NEVER(no_overrun, push_i && stat_o.full, "push into full queue")
  `LSSF_NEVER(no_underrun, pop_i && stat_o.empty, "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/lssf_back.sv =====
`default_nettype none
module lssf_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lssf_pkg::fifo_stat_t      fifo_stat_i,
  input  wire lssf_pkg::acc_t            fifo_data_i,
  output logic                           pop_o,
  input  wire logic [lssf_pkg::ThrW-1:0] thr_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output lssf_pkg::fit_t                 out_data_o
);
  import lssf_pkg::*;
  `include "assert_macros.svh"

  back_st_e state_q, state_d;
  acc_t     work_q;
  logic [ProdW-1:0]   prod_q, hold_q, den_q, rem_q;
  logic [QuotW-1:0]   nq_q;
  logic [DivCntW-1:0] cnt_q;
  logic               neg_q, degen_q;
  logic               out_valid_q;
  fit_t               out_q, fit;
  logic               out_load;

  logic [MulAW-1:0] op_a;
  logic [MulBW-1:0] op_b;
  logic [MulW-1:0]  mul;
  logic [ProdW-1:0] diff;
  logic [ProdW:0]   rem_sh, den_ext, rem_sub;
  logic             ge;
  logic             last_step;
  logic [SlopeW-1:0] lim, mag32;
  logic              over;

  // shared multiplier, one product per state
  always_comb begin
    unique case (state_q)
      StMulA:  begin op_a = MulAW'(work_q.count); op_b = work_q.sum_xx;         end
      StMulB:  begin op_a = work_q.sum_x;         op_b = MulBW'(work_q.sum_x);  end
      StMulC:  begin op_a = MulAW'(work_q.count); op_b = work_q.sum_xy;         end
      StMulD:  begin op_a = work_q.sum_x;         op_b = MulBW'(work_q.sum_y);  end
      default: begin op_a = '0;                   op_b = '0;                    end
    endcase
  end
  assign mul = {{MulBW{1'b0}}, op_a} * {{MulAW{1'b0}}, op_b};

  assign diff = (hold_q < prod_q) ? (prod_q - hold_q) : (hold_q - prod_q);

  // one restoring division step per cycle
  assign rem_sh  = {rem_q, nq_q[QuotW-1]};
  assign den_ext = {1'b0, den_q};
  assign ge      = (rem_sh >= den_ext);
  assign rem_sub = rem_sh - den_ext;
  assign last_step = (cnt_q == DivCntW'(QuotW - 1));

  // saturate the quotient and apply the sign
  always_comb begin
    lim   = neg_q ? MagLimNeg : MagLimPos;
    over  = (nq_q > {{(QuotW-SlopeW){1'b0}}, lim});
    mag32 = over ? lim : nq_q[SlopeW-1:0];
    fit.degenerate     = degen_q;
    fit.points_dropped = work_q.dropped;
    fit.point_count    = work_q.count;
    if (degen_q) begin
      fit.slope  = '0;
      fit.tilted = 1'b0;
    end else begin
      fit.slope  = $signed(neg_q ? (SlopeW'(0) - mag32) : mag32);
      fit.tilted = (mag32 > {1'b0, thr_i});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (!fifo_stat_i.empty) state_d = StMulA;
      StMulA: state_d = StMulB;
      StMulB: state_d = StMulC;
      StMulC: state_d = StMulD;
      StMulD: state_d = StSign;
      StSign: state_d = degen_q ? StOut : StDiv;
      StDiv:  if (last_step) state_d = StOut;
      StOut:  if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == StIdle) && !fifo_stat_i.empty;
    out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) work_q <= fifo_data_i;
    unique case (state_q)
      StMulA: prod_q <= ProdW'(mul);
      StMulB: begin
        hold_q <= prod_q;
        prod_q <= ProdW'(mul);
      end
      StMulC: begin
        den_q   <= hold_q - prod_q;
        degen_q <= (work_q.count < CountW'(2)) || (hold_q <= prod_q);
        prod_q  <= ProdW'(mul);
      end
      StMulD: begin
        hold_q <= prod_q;
        prod_q <= ProdW'(mul);
      end
      StSign: begin
        neg_q <= (hold_q < prod_q);
        nq_q  <= {diff, {FracW{1'b0}}};
        rem_q <= '0;
        cnt_q <= '0;
      end
      StDiv: begin
        rem_q <= ge ? rem_sub[ProdW-1:0] : rem_sh[ProdW-1:0];
        nq_q  <= {nq_q[QuotW-2:0], ge};
        cnt_q <= cnt_q + DivCntW'(1);
      end
      default: ;
    endcase
    if (out_load) out_q <= fit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LSSF_ASSERT(degen_zero_slope, (out_valid_q && out_q.degenerate) |-> (out_q.slope == '0 && !out_q.tilted), "degenerate fit with nonzero slope")
  `LSSF_NEVER(pop_only_idle, pop_o && state_q != StIdle, "queue popped while busy")

endmodule
`default_nettype wire

// ===== rtl/least_squares_slope_fit.sv =====
`default_nettype none
// Least-squares slope fit over a stream of horizon points. The front end takes
// one point per cycle and adds it to the count and the sums of x, y, x*x and
// x*y; a transfer marked last_point closes the set, which is queued (two
// deep) to the back end, and the sums clear at once so the next set streams
// in without a gap. Points past 4096 per set are dropped and flagged. The back
// end runs one set at a time: four products on a shared multiplier, a sign
// step, then a restoring divider that retires one quotient bit per cycle;
// a degenerate set skips the divider and goes from the sign step to the
// output register. The input stalls only when two closed sets wait in the
// queue. The slope is signed Q16.16, truncated toward zero and saturated;
// tilted compares its magnitude with thr_q (reset 6554, about 0.1).
module least_squares_slope_fit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire lssf_pkg::point_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output lssf_pkg::fit_t                 out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [lssf_pkg::ThrW-1:0] cfg_data_i
);
  import lssf_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic            push, pop;
  acc_t            push_data, pop_data;
  fifo_stat_t      fifo_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  lssf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lssf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  lssf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .fifo_data_i (pop_data),
    .pop_o       (pop),
    .thr_i       (thr_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
